// File: rtl/sbfh_pkg.sv
`default_nettype none

package sbfh_pkg;

    localparam int CW = 32;
    localparam int FW = CW + 1;
    localparam int PW = 2 * FW;
    localparam int TW = 32;
    localparam int IW = 3;

    localparam logic [IW-1:0] REG_BOX_MIN_X = IW'(0);
    localparam logic [IW-1:0] REG_BOX_MIN_Y = IW'(1);
    localparam logic [IW-1:0] REG_BOX_MIN_Z = IW'(2);
    localparam logic [IW-1:0] REG_BOX_MAX_X = IW'(3);
    localparam logic [IW-1:0] REG_BOX_MAX_Y = IW'(4);
    localparam logic [IW-1:0] REG_BOX_MAX_Z = IW'(5);
    localparam logic [IW-1:0] REG_BOX_VALID = IW'(6);

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [FW-1:0] fnum_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic [TW-1:0] tval_t;

    typedef struct packed {
        fnum_t n;
        fnum_t d;
    } frac_t;

    typedef struct packed {
        logic  par;
        fnum_t en_n;
        fnum_t ex_n;
        fnum_t d;
    } axis_t;

    typedef struct packed {
        coord_t min_x;
        coord_t min_y;
        coord_t min_z;
        coord_t max_x;
        coord_t max_y;
        coord_t max_z;
        logic   valid;
    } box_t;

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t sz;
        coord_t ex;
        coord_t ey;
        coord_t ez;
    } seg_t;

    // done: result already settled by the early checks (hit holds it)
    typedef struct packed {
        logic  done;
        logic  hit;
        frac_t tmin;
        frac_t tmax;
        axis_t ax_next;
        axis_t ax_last;
    } work_t;

endpackage

`default_nettype wire

// File: rtl/sbfh_prep.sv
`default_nettype none

module sbfh_prep import sbfh_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  box_t  box,
    input  logic  in_valid,
    output logic  in_ready,
    input  seg_t  seg,
    output logic  out_valid,
    input  logic  out_ready,
    output work_t out_work
);

    fnum_t s  [3];
    fnum_t e  [3];
    fnum_t lo [3];
    fnum_t hi [3];
    axis_t ax [3];
    logic  beyond;
    logic  in_box;
    logic  gt;

    logic  s1_valid_reg;
    logic  s1_done_reg;
    logic  s1_hit_reg;
    axis_t s1_ax_reg [3];
    logic  s1_ready;

    logic  s2_valid_reg;
    work_t s2_work_reg;
    work_t s2_work_next;
    logic  s2_ready;
    logic  x_en_take;
    logic  x_ex_take;

    always_comb
    begin
        s[0]  = FW'(seg.sx);
        s[1]  = FW'(seg.sy);
        s[2]  = FW'(seg.sz);
        e[0]  = FW'(seg.ex);
        e[1]  = FW'(seg.ey);
        e[2]  = FW'(seg.ez);
        lo[0] = FW'(box.min_x);
        lo[1] = FW'(box.min_y);
        lo[2] = FW'(box.min_z);
        hi[0] = FW'(box.max_x);
        hi[1] = FW'(box.max_y);
        hi[2] = FW'(box.max_z);
        beyond = 1'b0;
        in_box = 1'b1;
        gt     = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            gt = e[a] > s[a];
            ax[a].par  = e[a] == s[a];
            ax[a].d    = gt ? e[a] - s[a]  : s[a] - e[a];
            ax[a].en_n = gt ? lo[a] - s[a] : s[a] - hi[a];
            ax[a].ex_n = gt ? hi[a] - s[a] : s[a] - lo[a];
            if ((s[a] < lo[a] && e[a] < lo[a]) || (s[a] > hi[a] && e[a] > hi[a]))
                beyond = 1'b1;
            if (s[a] < lo[a] || s[a] > hi[a])
                in_box = 1'b0;
        end
    end

    assign s2_ready = ~s2_valid_reg | out_ready;
    assign s1_ready = ~s1_valid_reg | s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready)
        begin
            s1_done_reg <= ~box.valid | beyond | in_box;
            s1_hit_reg  <= box.valid & ~beyond & in_box;
            for (int a = 0; a < 3; a++)
                s1_ax_reg[a] <= ax[a];
        end
    end

    // x axis against the start values 0/1 and 1/1
    always_comb
    begin
        x_en_take = ~s1_ax_reg[0].par && ($signed(s1_ax_reg[0].en_n) > $signed(FW'(0)));
        x_ex_take = ~s1_ax_reg[0].par &&
                    ($signed(s1_ax_reg[0].ex_n) < $signed(s1_ax_reg[0].d));
        s2_work_next.done    = s1_done_reg;
        s2_work_next.hit     = s1_hit_reg;
        s2_work_next.tmin.n  = x_en_take ? s1_ax_reg[0].en_n : FW'(0);
        s2_work_next.tmin.d  = x_en_take ? s1_ax_reg[0].d    : FW'(1);
        s2_work_next.tmax.n  = x_ex_take ? s1_ax_reg[0].ex_n : FW'(1);
        s2_work_next.tmax.d  = x_ex_take ? s1_ax_reg[0].d    : FW'(1);
        s2_work_next.ax_next = s1_ax_reg[1];
        s2_work_next.ax_last = s1_ax_reg[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s2_ready)
            s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready)
            s2_work_reg <= s2_work_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_work  = s2_work_reg;

endmodule

`default_nettype wire

// File: rtl/sbfh_slab.sv
`default_nettype none

module sbfh_slab import sbfh_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  work_t in_work,
    output logic  out_valid,
    input  logic  out_ready,
    output work_t out_work
);

    logic  m_valid_reg;
    work_t m_work_reg;
    prod_t pe_a_reg;
    prod_t pe_b_reg;
    prod_t px_a_reg;
    prod_t px_b_reg;
    logic  m_ready;

    logic  c_valid_reg;
    work_t c_work_reg;
    work_t c_work_next;
    logic  c_ready;
    logic  en_take;
    logic  ex_take;

    assign c_ready  = ~c_valid_reg | out_ready;
    assign m_ready  = ~m_valid_reg | c_ready;
    assign in_ready = m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (m_ready)
            m_valid_reg <= in_valid;
    end

    // cross products of the axis fractions against the running tmin and tmax
    always_ff @(posedge clk)
    begin
        if (m_ready)
        begin
            m_work_reg <= in_work;
            pe_a_reg   <= $signed(in_work.ax_next.en_n) * $signed(in_work.tmin.d);
            pe_b_reg   <= $signed(in_work.tmin.n) * $signed(in_work.ax_next.d);
            px_a_reg   <= $signed(in_work.ax_next.ex_n) * $signed(in_work.tmax.d);
            px_b_reg   <= $signed(in_work.tmax.n) * $signed(in_work.ax_next.d);
        end
    end

    always_comb
    begin
        en_take = ~m_work_reg.ax_next.par && ($signed(pe_a_reg) > $signed(pe_b_reg));
        ex_take = ~m_work_reg.ax_next.par && ($signed(px_a_reg) < $signed(px_b_reg));
        c_work_next = m_work_reg;
        if (en_take)
        begin
            c_work_next.tmin.n = m_work_reg.ax_next.en_n;
            c_work_next.tmin.d = m_work_reg.ax_next.d;
        end
        if (ex_take)
        begin
            c_work_next.tmax.n = m_work_reg.ax_next.ex_n;
            c_work_next.tmax.d = m_work_reg.ax_next.d;
        end
        c_work_next.ax_next = m_work_reg.ax_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (c_ready)
            c_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (c_ready)
            c_work_reg <= c_work_next;
    end

    assign out_valid = c_valid_reg;
    assign out_work  = c_work_reg;

endmodule

`default_nettype wire

// File: rtl/sbfh_final.sv
`default_nettype none

module sbfh_final import sbfh_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  work_t in_work,
    output logic  out_valid,
    input  logic  out_ready,
    output logic  hit,
    output tval_t t_numerator,
    output tval_t t_denominator
);

    logic  m_valid_reg;
    logic  m_done_reg;
    logic  m_hit_reg;
    frac_t m_tmin_reg;
    prod_t pa_reg;
    prod_t pb_reg;
    logic  m_ready;

    logic  o_valid_reg;
    logic  o_hit_reg;
    tval_t o_num_reg;
    tval_t o_den_reg;
    logic  o_ready;
    logic  miss;
    logic  hit_next;

    assign o_ready  = ~o_valid_reg | out_ready;
    assign m_ready  = ~m_valid_reg | o_ready;
    assign in_ready = m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (m_ready)
            m_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (m_ready)
        begin
            m_done_reg <= in_work.done;
            m_hit_reg  <= in_work.hit;
            m_tmin_reg <= in_work.tmin;
            pa_reg     <= $signed(in_work.tmin.n) * $signed(in_work.tmax.d);
            pb_reg     <= $signed(in_work.tmax.n) * $signed(in_work.tmin.d);
        end
    end

    // entry after exit: miss
    always_comb
    begin
        miss     = $signed(pa_reg) > $signed(pb_reg);
        hit_next = m_done_reg ? m_hit_reg : ~miss;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            o_valid_reg <= 1'b0;
        else if (o_ready)
            o_valid_reg <= m_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (o_ready)
        begin
            o_hit_reg <= hit_next;
            if (m_done_reg || miss)
            begin
                o_num_reg <= TW'(0);
                o_den_reg <= TW'(1);
            end
            else
            begin
                o_num_reg <= tval_t'(m_tmin_reg.n);
                o_den_reg <= tval_t'(m_tmin_reg.d);
            end
        end
    end

    assign out_valid     = o_valid_reg;
    assign hit           = o_hit_reg;
    assign t_numerator   = o_num_reg;
    assign t_denominator = o_den_reg;

endmodule

`default_nettype wire

// File: rtl/segment_box_first_hit_unit.sv
`default_nettype none

// channel   dir   handshake               payload
// in        in    in_valid / in_stall     start_x..z, end_x..z
// out       out   out_valid / out_stall   hit, t_numerator, t_denominator
// cfg       in    cfg_write               cfg_index, cfg_data
//
// One segment per cycle while in_stall is low; the result passes through the
// chain of cross-multiply compares (x select, y and z slabs, final check).
// Reset clears the stage valid bits and the box registers.
// Stall from the output backs up stage by stage; empty stages keep
// taking input while a result waits.

module segment_box_first_hit_unit import sbfh_pkg::*; (
    input  wire          clk,
    input  wire          rst_n,
    input  logic         cfg_write,
    input  logic [IW-1:0] cfg_index,
    input  logic [CW-1:0] cfg_data,
    input  logic         in_valid,
    output logic         in_stall,
    input  coord_t       start_x,
    input  coord_t       start_y,
    input  coord_t       start_z,
    input  coord_t       end_x,
    input  coord_t       end_y,
    input  coord_t       end_z,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         hit,
    output tval_t        t_numerator,
    output tval_t        t_denominator
);

    box_t  box_reg;
    seg_t  seg;

    logic  prep_ready;
    logic  prep_valid;
    work_t prep_work;
    logic  sy_ready;
    logic  sy_valid;
    work_t sy_work;
    logic  sz_ready;
    logic  sz_valid;
    work_t sz_work;
    logic  fin_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_BOX_MIN_X: box_reg.min_x <= cfg_data;
                REG_BOX_MIN_Y: box_reg.min_y <= cfg_data;
                REG_BOX_MIN_Z: box_reg.min_z <= cfg_data;
                REG_BOX_MAX_X: box_reg.max_x <= cfg_data;
                REG_BOX_MAX_Y: box_reg.max_y <= cfg_data;
                REG_BOX_MAX_Z: box_reg.max_z <= cfg_data;
                REG_BOX_VALID: box_reg.valid <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    assign seg.sx = start_x;
    assign seg.sy = start_y;
    assign seg.sz = start_z;
    assign seg.ex = end_x;
    assign seg.ey = end_y;
    assign seg.ez = end_z;

    assign in_stall = ~prep_ready;

    sbfh_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .box       (box_reg),
        .in_valid  (in_valid),
        .in_ready  (prep_ready),
        .seg       (seg),
        .out_valid (prep_valid),
        .out_ready (sy_ready),
        .out_work  (prep_work)
    );

    sbfh_slab u_slab_y (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid),
        .in_ready  (sy_ready),
        .in_work   (prep_work),
        .out_valid (sy_valid),
        .out_ready (sz_ready),
        .out_work  (sy_work)
    );

    sbfh_slab u_slab_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sy_valid),
        .in_ready  (sz_ready),
        .in_work   (sy_work),
        .out_valid (sz_valid),
        .out_ready (fin_ready),
        .out_work  (sz_work)
    );

    sbfh_final u_final (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (sz_valid),
        .in_ready      (fin_ready),
        .in_work       (sz_work),
        .out_valid     (out_valid),
        .out_ready     (~out_stall),
        .hit           (hit),
        .t_numerator   (t_numerator),
        .t_denominator (t_denominator)
    );

endmodule

`default_nettype wire

// File: dv/segment_box_first_hit_unit_tb.sv
`timescale 1ns / 100ps

module segment_box_first_hit_unit_tb;
    import sbfh_pkg::*;

    localparam longint CMIN = -64'sd2147483648;
    localparam longint CMAX = 64'sd2147483647;
    localparam int CYCLE_LIMIT = 300000;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        bit          hit;
        bit [TW-1:0] num;
        bit [TW-1:0] den;
    } contact_t;

    typedef struct {
        longint n;
        longint d;
    } ratio_t;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cfg_write = 1'b0;
    logic [IW-1:0]  cfg_index = '0;
    logic [CW-1:0]  cfg_data = '0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    coord_t         start_x = '0;
    coord_t         start_y = '0;
    coord_t         start_z = '0;
    coord_t         end_x = '0;
    coord_t         end_y = '0;
    coord_t         end_z = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    logic           hit;
    tval_t          t_numerator;
    tval_t          t_denominator;

    bit [CW-1:0]    box_reg [7];
    seg_t           pending_segs [$];
    contact_t       expected_contacts [$];
    seg_t           drv_seg;
    int             tx_idle_pct = 0;
    int             rx_stall_pct = 0;
    int             error_count = 0;
    int             cycle_count = 0;
    int             hold_requests = 0;
    int             hold_served = 0;
    int             stall_hold_left = 0;

    segment_box_first_hit_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .start_x(start_x),
        .start_y(start_y),
        .start_z(start_z),
        .end_x(end_x),
        .end_y(end_y),
        .end_z(end_z),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .hit(hit),
        .t_numerator(t_numerator),
        .t_denominator(t_denominator)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sign of a ratio with positive denominator, then cross-multiplied magnitudes
    function automatic int ratio_cmp(ratio_t a, ratio_t b);
        int sa;
        int sb;
        bit [63:0] ua;
        bit [63:0] ub;
        sa = (a.n < 0) ? -1 : ((a.n > 0) ? 1 : 0);
        sb = (b.n < 0) ? -1 : ((b.n > 0) ? 1 : 0);
        if (sa != sb)
            return (sa < sb) ? -1 : 1;
        if (sa == 0)
            return 0;
        ua = 64'((a.n < 0) ? -a.n : a.n) * 64'(b.d);
        ub = 64'((b.n < 0) ? -b.n : b.n) * 64'(a.d);
        if (ua == ub)
            return 0;
        if (sa > 0)
            return (ua < ub) ? -1 : 1;
        return (ua < ub) ? 1 : -1;
    endfunction

    function automatic contact_t predict_contact(seg_t sg);
        longint s [3];
        longint e [3];
        longint lo [3];
        longint hi [3];
        ratio_t t_in;
        ratio_t t_out;
        ratio_t f;
        contact_t res;
        bit in_box;
        s[0] = coord_t'(sg.sx);
        s[1] = coord_t'(sg.sy);
        s[2] = coord_t'(sg.sz);
        e[0] = coord_t'(sg.ex);
        e[1] = coord_t'(sg.ey);
        e[2] = coord_t'(sg.ez);
        for (int a = 0; a < 3; a++)
        begin
            lo[a] = coord_t'(box_reg[a]);
            hi[a] = coord_t'(box_reg[a + 3]);
        end
        res.hit = 1'b0;
        res.num = '0;
        res.den = 1;
        if (!box_reg[REG_BOX_VALID][0])
            return res;
        for (int a = 0; a < 3; a++)
        begin
            if (s[a] < lo[a] && e[a] < lo[a])
                return res;
            if (s[a] > hi[a] && e[a] > hi[a])
                return res;
        end
        in_box = 1'b1;
        for (int a = 0; a < 3; a++)
            if (s[a] < lo[a] || s[a] > hi[a])
                in_box = 1'b0;
        if (in_box)
        begin
            res.hit = 1'b1;
            return res;
        end
        t_in.n = 0;
        t_in.d = 1;
        t_out.n = 1;
        t_out.d = 1;
        for (int a = 0; a < 3; a++)
        begin
            if (s[a] == e[a])
            begin
                if (s[a] < lo[a])
                    return res;
                continue;
            end
            if (e[a] > s[a])
            begin
                f.n = lo[a] - s[a];
                f.d = e[a] - s[a];
            end
            else
            begin
                f.n = s[a] - hi[a];
                f.d = s[a] - e[a];
            end
            if (ratio_cmp(t_in, f) < 0)
            begin
                t_in = f;
                if (ratio_cmp(t_in, t_out) > 0)
                    return res;
            end
        end
        for (int a = 0; a < 3; a++)
        begin
            if (s[a] == e[a])
            begin
                if (s[a] > hi[a])
                    return res;
                continue;
            end
            if (e[a] > s[a])
            begin
                f.n = hi[a] - s[a];
                f.d = e[a] - s[a];
            end
            else
            begin
                f.n = s[a] - lo[a];
                f.d = s[a] - e[a];
            end
            if (ratio_cmp(t_out, f) > 0)
            begin
                t_out = f;
                if (ratio_cmp(t_in, t_out) > 0)
                    return res;
            end
        end
        res.hit = 1'b1;
        res.num = t_in.n[31:0];
        res.den = t_in.d[31:0];
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        if (error_count < 40)
            $display("mismatch %s at cycle %0d: got %0h, expected %0h",
                     what, cycle_count, got, want);
        error_count++;
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                expected_contacts.insert(expected_contacts.size(), predict_contact(drv_seg));
            if (!in_valid || !in_stall)
            begin
                if (pending_segs.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    drv_seg = pending_segs.pop_front();
                    in_valid <= 1'b1;
                    start_x <= drv_seg.sx;
                    start_y <= drv_seg.sy;
                    start_z <= drv_seg.sz;
                    end_x <= drv_seg.ex;
                    end_y <= drv_seg.ey;
                    end_z <= drv_seg.ez;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver
    always @(posedge clk)
    begin
        contact_t want;
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_contacts.size() == 0)
                    report_mismatch("unexpected transfer", hit, 0);
                else
                begin
                    want = expected_contacts.pop_front();
                    if (hit !== want.hit)
                        report_mismatch("hit", hit, want.hit);
                    if (t_numerator !== want.num)
                        report_mismatch("t_numerator", t_numerator, want.num);
                    if (t_denominator !== want.den)
                        report_mismatch("t_denominator", t_denominator, want.den);
                end
            end
            out_stall <= (stall_hold_left > 0) || ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // long receiver hold-off
    always @(posedge clk)
    begin
        if (hold_served < hold_requests)
        begin
            stall_hold_left <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end
        else if (stall_hold_left > 0)
            stall_hold_left <= stall_hold_left - 1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint rand_between(longint a, longint b);
        bit [63:0] w;
        bit [63:0] r;
        if (b <= a)
            return a;
        w = 64'(b - a) + 1;
        r = {$urandom, $urandom};
        return a + longint'(r % w);
    endfunction

    function automatic coord_t pick_coord(longint lo, longint hi);
        longint a;
        longint b;
        longint span;
        longint v;
        a = (lo <= hi) ? lo : hi;
        b = (lo <= hi) ? hi : lo;
        span = (b - a) / 2 + 4;
        case ($urandom_range(0, 11))
            0, 1: return coord_t'($urandom);
            2:
            begin
                case ($urandom_range(0, 3))
                    0: return coord_t'(CMIN);
                    1: return coord_t'(CMAX);
                    2: return '0;
                    default: return '1;
                endcase
            end
            3: return coord_t'(a);
            4: return coord_t'(b);
            default:
            begin
                v = rand_between(a - span, b + span);
                if (v < CMIN)
                    v = CMIN;
                if (v > CMAX)
                    v = CMAX;
                return coord_t'(v);
            end
        endcase
    endfunction

    task automatic push_seg(longint x0, longint y0, longint z0,
                            longint x1, longint y1, longint z1);
        seg_t sg;
        sg.sx = coord_t'(x0);
        sg.sy = coord_t'(y0);
        sg.sz = coord_t'(z0);
        sg.ex = coord_t'(x1);
        sg.ey = coord_t'(y1);
        sg.ez = coord_t'(z1);
        pending_segs.insert(pending_segs.size(), sg);
    endtask

    task automatic add_random_segs(int count);
        longint lo [3];
        longint hi [3];
        coord_t p0 [3];
        coord_t p1 [3];
        bit inside_ok;
        seg_t sg;
        inside_ok = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            lo[a] = coord_t'(box_reg[a]);
            hi[a] = coord_t'(box_reg[a + 3]);
            if (lo[a] > hi[a])
                inside_ok = 1'b0;
        end
        for (int i = 0; i < count; i++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                p0[a] = pick_coord(lo[a], hi[a]);
                p1[a] = pick_coord(lo[a], hi[a]);
                if ($urandom_range(0, 99) < 12)
                    p1[a] = p0[a];
            end
            if (inside_ok && $urandom_range(0, 99) < 15)
                for (int a = 0; a < 3; a++)
                    p0[a] = coord_t'(rand_between(lo[a], hi[a]));
            if ($urandom_range(0, 99) < 8)
                for (int a = 0; a < 3; a++)
                begin
                    p0[a] = coord_t'($urandom);
                    p1[a] = coord_t'($urandom);
                end
            sg.sx = p0[0];
            sg.sy = p0[1];
            sg.sz = p0[2];
            sg.ex = p1[0];
            sg.ey = p1[1];
            sg.ez = p1[2];
            pending_segs.insert(pending_segs.size(), sg);
        end
    endtask

    task automatic write_box_reg(logic [IW-1:0] idx, bit [CW-1:0] val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        box_reg[idx] = val;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic set_box(longint x0, longint y0, longint z0,
                           longint x1, longint y1, longint z1, bit valid);
        write_box_reg(REG_BOX_MIN_X, CW'(x0));
        write_box_reg(REG_BOX_MIN_Y, CW'(y0));
        write_box_reg(REG_BOX_MIN_Z, CW'(z0));
        write_box_reg(REG_BOX_MAX_X, CW'(x1));
        write_box_reg(REG_BOX_MAX_Y, CW'(y1));
        write_box_reg(REG_BOX_MAX_Z, CW'(z1));
        write_box_reg(REG_BOX_VALID, {CW'($urandom) & ~CW'(1)} | CW'(valid));
    endtask

    task automatic set_random_box(longint size);
        longint lo [3];
        for (int a = 0; a < 3; a++)
            lo[a] = rand_between(-4 * size, 4 * size);
        set_box(lo[0], lo[1], lo[2],
                lo[0] + rand_between(0, size), lo[1] + rand_between(0, size),
                lo[2] + rand_between(0, size), 1'b1);
    endtask

    task automatic set_idling(int tx_pct, int rx_pct);
        @(negedge clk);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_segs.size() != 0 || in_valid || expected_contacts.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        for (int i = 0; i < 7; i++)
            box_reg[i] = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty box after reset
        set_idling(0, 0);
        push_seg(0, 0, 0, 0, 0, 0);
        push_seg(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        push_seg(-1, 5, -7, 3, -2, 9);
        wait_drained();

        set_box(-10, -10, -10, 10, 10, 10, 1'b1);
        set_idling(0, 0);
        push_seg(0, 0, 0, 100, 100, 100);
        push_seg(10, -10, 10, 50, 50, 50);
        push_seg(-20, 0, 0, 20, 0, 0);
        push_seg(20, 0, 0, -20, 0, 0);
        push_seg(-20, 0, 0, -11, 9, 9);
        push_seg(0, 0, 11, 5, 5, 30);
        push_seg(-20, -20, 0, 0, 0, 0);
        push_seg(-20, -30, 0, 0, -10, 0);
        push_seg(-30, -20, 0, 30, -10, 5);
        push_seg(-20, 0, 0, -10, 0, 0);
        push_seg(-20, 25, 0, 0, -25, 0);
        push_seg(-20, 5, 0, 0, 40, 0);
        push_seg(15, 15, 15, 15, 15, 15);
        push_seg(3, 3, 3, 3, 3, 3);
        push_seg(-20, 11, 0, 20, 11, 0);
        push_seg(-20, -20, -20, 20, 20, 20);
        push_seg(-25, 5, 12, 25, 5, -12);
        push_seg(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        push_seg(CMAX, 0, 0, CMIN, 0, 0);
        wait_drained();

        set_random_box(1000);
        set_idling(0, 0);
        add_random_segs(150);
        wait_drained();

        // box at the coordinate extremes
        set_box(CMIN, CMIN, 0, CMAX, -1, CMAX, 1'b1);
        set_idling(78, 0);
        push_seg(0, CMAX, CMIN, 0, CMIN, CMAX);
        push_seg(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
        push_seg(5, 0, -1, 5, -1, 0);
        add_random_segs(100);
        wait_drained();

        set_random_box(1 << 20);
        set_idling(0, 78);
        add_random_segs(100);
        wait_drained();

        // point box, then one inverted axis
        set_box(7, -3, 0, 7, -3, 0, 1'b1);
        set_idling(31, 31);
        push_seg(0, -3, 0, 14, -3, 0);
        add_random_segs(40);
        wait_drained();
        set_box(50, -100, -100, -50, 100, 100, 1'b1);
        set_idling(31, 31);
        add_random_segs(40);
        wait_drained();

        // receiver holds off while the sender keeps offering
        set_random_box(64);
        set_idling(0, 0);
        hold_requests = hold_requests + 1;
        add_random_segs(60);
        wait_drained();

        set_box(-5, -5, -5, 5, 5, 5, 1'b0);
        set_idling(31, 31);
        add_random_segs(40);
        wait_drained();

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
